[rtl/mtp_pkg.sv]
package mtp_pkg;

    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned TAP_OFFSET  = 397;
    localparam int unsigned INDEX_W     = $clog2(STATE_WORDS);

    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [31:0]        word_t;

    // Request codes on the command port.
    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;

    localparam index_t LAST_INDEX = index_t'(STATE_WORDS - 1);
    localparam index_t TAP_STEP   = index_t'(TAP_OFFSET);
    localparam index_t TAP_WRAP   = index_t'(STATE_WORDS - TAP_OFFSET);

    localparam word_t TWIST_MATRIX = 32'h9908_b0df;
    localparam word_t HIGH_BIT     = 32'h8000_0000;
    localparam word_t LOW_BITS     = 32'h7fff_ffff;
    localparam word_t SEED_MULT    = 32'h6c07_8965;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;

    // Combine the upper bit of the current word with the lower bits of the
    // following word and fold in the tap word.
    function automatic word_t twist(word_t cur_word, word_t nxt_word, word_t tap_word);
        word_t mixed;
        word_t y;
        mixed = (cur_word & HIGH_BIT) | (nxt_word & LOW_BITS);
        y     = tap_word ^ (mixed >> 1);
        if (nxt_word[0])
        begin
            y = y ^ TWIST_MATRIX;
        end
        return y;
    endfunction

    function automatic word_t temper(word_t value);
        word_t y;
        y = value;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Index arithmetic modulo the table depth.
    function automatic index_t next_index(index_t idx);
        return (idx == LAST_INDEX) ? '0 : idx + index_t'(1);
    endfunction

    function automatic index_t tap_index(index_t idx);
        return (idx >= TAP_WRAP) ? idx - TAP_WRAP : idx + TAP_STEP;
    endfunction

endpackage

[rtl/mtp_ram.sv]
// State table: one write port and two registered read ports.
module mtp_ram
    import mtp_pkg::*;
(
    input  logic   clk,
    input  logic   wr_en,
    input  index_t wr_addr,
    input  word_t  wr_data,
    input  logic   rd_en,
    input  index_t rd_addr_a,
    input  index_t rd_addr_b,
    output word_t  rd_data_a,
    output word_t  rd_data_b
);

    word_t mem [STATE_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[rtl/mersenne_twister_prng.sv]
// Generate request: the table is read on acceptance, then ST_GEN twists and writes the word
// back and registers done and random_word; busy is high for a single cycle, in ST_GEN only.
// Reseed request: busy while ST_SEED writes words 1 to 623, one table word written per cycle.
// Reset clears the index and the control state; the table holds garbage until reseeded.
// The receiver cannot stall: each result is marked by done, which is high for one cycle.
module mersenne_twister_prng
    import mtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] seed_value,
    output logic [31:0] random_word,
    output logic        done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_SEED
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Index of the word that the next generate request twists.
    index_t index_reg;
    index_t index_next;

    // Untwisted value of the word at index_reg. It was read as the "next"
    // word of the previous request (or is the seed after a reseed), and no
    // write touches it before it is used, so no third read port is needed.
    word_t cur_word_reg;
    word_t cur_word_next;

    // Seeding recurrence: previous word and the position being written.
    word_t  last_word_reg;
    word_t  last_word_next;
    index_t seed_cnt_reg;
    index_t seed_cnt_next;

    word_t out_word_reg;
    word_t out_word_next;
    logic  done_reg;
    logic  done_next;

    logic   ram_wr_en;
    index_t ram_wr_addr;
    word_t  ram_wr_data;
    logic   ram_rd_en;
    word_t  ram_rd_a;
    word_t  ram_rd_b;

    word_t twisted;
    word_t seed_mix;
    word_t seed_word;

    mtp_ram u_ram (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_en     (ram_rd_en),
        .rd_addr_a (next_index(index_reg)),
        .rd_addr_b (tap_index(index_reg)),
        .rd_data_a (ram_rd_a),
        .rd_data_b (ram_rd_b)
    );

    // Port A returns the following word, port B the tap word.
    assign twisted = twist(cur_word_reg, ram_rd_a, ram_rd_b);

    // One step of the linear seeding recurrence, modulo 2^32.
    assign seed_mix  = last_word_reg ^ (last_word_reg >> 30);
    assign seed_word = word_t'(SEED_MULT * seed_mix) + word_t'(seed_cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        cur_word_next  = cur_word_reg;
        last_word_next = last_word_reg;
        seed_cnt_next  = seed_cnt_reg;
        out_word_next  = out_word_reg;
        done_next      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = index_reg;
        ram_wr_data    = twisted;
        ram_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_RESEED)
                    begin
                        // The seed itself is word zero.
                        ram_wr_en      = 1'b1;
                        ram_wr_addr    = '0;
                        ram_wr_data    = seed_value;
                        last_word_next = seed_value;
                        cur_word_next  = seed_value;
                        index_next     = '0;
                        seed_cnt_next  = index_t'(1);
                        state_next     = ST_SEED;
                    end
                    else if (command == CMD_GENERATE)
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_GEN;
                    end
                end
            end

            ST_GEN:
            begin
                // Twist in place, temper into the output register, advance.
                ram_wr_en     = 1'b1;
                ram_wr_addr   = index_reg;
                ram_wr_data   = twisted;
                out_word_next = temper(twisted);
                done_next     = 1'b1;
                cur_word_next = ram_rd_a;
                index_next    = next_index(index_reg);
                state_next    = ST_IDLE;
            end

            ST_SEED:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = seed_cnt_reg;
                ram_wr_data    = seed_word;
                last_word_next = seed_word;
                seed_cnt_next  = seed_cnt_reg + index_t'(1);
                if (seed_cnt_reg == LAST_INDEX)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            index_reg    <= '0;
            seed_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            index_reg    <= index_next;
            seed_cnt_reg <= seed_cnt_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cur_word_reg  <= cur_word_next;
        last_word_reg <= last_word_next;
        out_word_reg  <= out_word_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign random_word = out_word_reg;

endmodule
